// ===== sv/brfa_pkg.sv =====
// shared constants and types for the burst register file access core
package brfa_pkg;

    // defaults of the top level parameters
    localparam int NUM_REGISTERS_DEF = 32;
    localparam int HEADER_LENGTH_DEF = 7;

    // configuration register indexes
    localparam int          CFG_INDEX_W    = 8;
    localparam logic [7:0]  CFG_WRITE_CODE = 8'd0;
    localparam logic [7:0]  CFG_READ_CODE  = 8'd1;

    // reset values of the command codes
    localparam logic [7:0]  WRITE_CODE_RST = 8'd119;
    localparam logic [7:0]  READ_CODE_RST  = 8'd114;

    // error response fields
    localparam logic [7:0]  ERROR_COMMAND   = 8'd101;
    localparam logic [7:0]  ERROR_LENGTH    = 8'd7;
    localparam logic [7:0]  ERR_BAD_ADDRESS = 8'd0;
    localparam logic [7:0]  ERR_BAD_COUNT   = 8'd1;
    localparam logic [7:0]  ERR_BAD_COMMAND = 8'd2;

    // write position saturates here
    localparam logic [5:0]  OFFSET_MAX = 6'd63;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    typedef struct packed {
        logic [7:0] command;
        logic [7:0] length;
        logic [7:0] address_or_error;
        logic [7:0] count;
        logic [7:0] value;
        logic       last;
    } resp_t;

endpackage

// ===== sv/burst_register_file_access_core.sv =====
// top level: byte register file served by burst read and write command frames
//
//  channel | direction | handshake           | moves
//  --------+-----------+---------------------+----------------------------------------
//  s_      | in        | s_valid / s_ready   | one frame item (header + payload byte)
//  m_      | out       | m_valid / m_ready   | one response item (header + read value)
//  cfg_    | in        | cfg_valid/cfg_ready | one command code register write
//
//  write items and single-result items are handled in the idle state; an input transfer is taken
//  only while the output register is empty or being emptied, so a waiting result stalls it
//  a read of count registers holds the input until its last value is loaded into the output
//  register, each value passing the store's registered read port and the pending stage; no input transfer meanwhile
//  reset clears the valid bit of every register entry at once: no clearing pass
//  a stalled m_ready holds the burst; the next store read waits for a free slot
module burst_register_file_access_core
    import brfa_pkg::*;
#(
    parameter int NUM_REGISTERS = NUM_REGISTERS_DEF,
    parameter int HEADER_LENGTH = HEADER_LENGTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_frame_command,
    input  logic [7:0]             s_start_address,
    input  logic [7:0]             s_register_count,
    input  logic [7:0]             s_payload_byte,
    input  logic                   s_payload_last,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_resp_command,
    output logic [7:0]             m_resp_length,
    output logic [7:0]             m_resp_address_or_error,
    output logic [7:0]             m_resp_count,
    output logic [7:0]             m_resp_value,
    output logic                   m_resp_last,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data
);

    // index width of the store and width of the burst counter
    localparam int AW = (NUM_REGISTERS > 1) ? $clog2(NUM_REGISTERS) : 1;
    localparam int CW = $clog2(NUM_REGISTERS + 1);
    localparam logic [8:0] NUM9    = 9'(NUM_REGISTERS);
    localparam logic [7:0] HDR_LEN = 8'(HEADER_LENGTH);

    // command code registers
    logic [7:0] wr_code_reg, rd_code_reg;

    // register store: data memory plus a valid bit per entry
    logic [7:0]               store_mem [NUM_REGISTERS];
    logic [NUM_REGISTERS-1:0] vld_reg;

    // control state
    state_t        state_reg, state_next;
    logic [5:0]    offset_reg, offset_next;
    logic          m_valid_reg, m_valid_next;
    resp_t         resp_reg, resp_next;

    // burst read state
    logic [CW-1:0] rd_left_reg, rd_left_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic          pend_reg, pend_next;
    logic          pend_last_reg, pend_last_next;
    logic [7:0]    rd_data_reg;
    logic          rd_vld_reg;
    resp_t         rd_hdr_reg, rd_hdr_next;

    // decode of the incoming item
    logic          s_fire, is_wr, is_rd, addr_bad, cnt_bad, hdr_ok, slot_free;
    logic [7:0]    hdr_err;
    logic          wr_en, rd_en, load_out;
    logic [AW-1:0] wr_idx;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_code_reg <= WRITE_CODE_RST;
            rd_code_reg <= READ_CODE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_INDEX_W'(CFG_WRITE_CODE): wr_code_reg <= cfg_data;
                CFG_INDEX_W'(CFG_READ_CODE):  rd_code_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // output slot is free when empty or being emptied this cycle
    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && slot_free;
    assign s_fire    = s_valid && s_ready;

    // write takes precedence when both codes are equal
    assign is_wr = (s_frame_command == wr_code_reg);
    assign is_rd = !is_wr && (s_frame_command == rd_code_reg);

    // header check, bad address wins over bad count
    assign addr_bad = {1'b0, s_start_address} >= NUM9;
    assign cnt_bad  = (s_register_count == 8'd0)
                   || (({1'b0, s_start_address} + {1'b0, s_register_count}) > NUM9);
    assign hdr_ok   = !addr_bad && !cnt_bad;
    assign hdr_err  = addr_bad ? ERR_BAD_ADDRESS : ERR_BAD_COUNT;

    // payload byte lands at start plus offset while offset is below count
    assign wr_idx = AW'(s_start_address + {2'b00, offset_reg});
    assign wr_en  = s_fire && is_wr && hdr_ok && ({2'b00, offset_reg} < s_register_count);

    // a read result leaves the pending stage when the output slot is free
    assign load_out = pend_reg && slot_free;
    assign rd_en    = (state_reg == ST_READ) && (rd_left_reg != '0)
                   && (!pend_reg || load_out);

    always_comb begin
        state_next     = state_reg;
        offset_next    = offset_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        resp_next      = resp_reg;
        rd_left_next   = rd_left_reg;
        rd_addr_next   = rd_addr_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        rd_hdr_next    = rd_hdr_reg;

        if (s_fire) begin
            if (is_wr) begin
                if (hdr_ok && offset_reg != OFFSET_MAX) begin
                    offset_next = offset_reg + 6'd1;
                end
                if (s_payload_last) begin
                    m_valid_next = 1'b1;
                    if (hdr_ok) begin
                        resp_next = '{s_frame_command, HDR_LEN, s_start_address,
                                      s_register_count, 8'd0, 1'b1};
                    end else begin
                        resp_next = '{ERROR_COMMAND, ERROR_LENGTH, hdr_err,
                                      8'd0, 8'd0, 1'b1};
                    end
                end
            end else if (is_rd) begin
                offset_next = '0;
                if (hdr_ok) begin
                    // burst: header kept, values follow from the store
                    state_next   = ST_READ;
                    rd_left_next = CW'(s_register_count);
                    rd_addr_next = AW'(s_start_address);
                    rd_hdr_next  = '{s_frame_command, HDR_LEN + s_register_count,
                                     s_start_address, s_register_count, 8'd0, 1'b0};
                end else begin
                    m_valid_next = 1'b1;
                    resp_next    = '{ERROR_COMMAND, ERROR_LENGTH, hdr_err,
                                     8'd0, 8'd0, 1'b1};
                end
            end else if (s_payload_last) begin
                m_valid_next = 1'b1;
                resp_next    = '{ERROR_COMMAND, ERROR_LENGTH, ERR_BAD_COMMAND,
                                 8'd0, 8'd0, 1'b1};
            end
            if (s_payload_last) begin
                offset_next = '0;
            end
        end

        if (load_out) begin
            m_valid_next   = 1'b1;
            resp_next      = rd_hdr_reg;
            resp_next.value = rd_vld_reg ? rd_data_reg : 8'd0;
            resp_next.last = pend_last_reg;
            pend_next      = 1'b0;
            if (pend_last_reg) begin
                state_next = ST_IDLE;
            end
        end

        if (rd_en) begin
            rd_left_next   = rd_left_reg - CW'(1);
            rd_addr_next   = rd_addr_reg + AW'(1);
            pend_next      = 1'b1;
            pend_last_next = (rd_left_reg == CW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            offset_reg    <= '0;
            m_valid_reg   <= 1'b0;
            rd_left_reg   <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            offset_reg    <= offset_next;
            m_valid_reg   <= m_valid_next;
            rd_left_reg   <= rd_left_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        resp_reg    <= resp_next;
        rd_addr_reg <= rd_addr_next;
        rd_hdr_reg  <= rd_hdr_next;
    end

    // valid bits: cleared at reset, set by the first write of an entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr_en) begin
            vld_reg[wr_idx] <= 1'b1;
        end
    end

    // store memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_idx] <= s_payload_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_addr_reg];
            rd_vld_reg  <= vld_reg[rd_addr_reg];
        end
    end

    assign m_valid                 = m_valid_reg;
    assign m_resp_command          = resp_reg.command;
    assign m_resp_length           = resp_reg.length;
    assign m_resp_address_or_error = resp_reg.address_or_error;
    assign m_resp_count            = resp_reg.count;
    assign m_resp_value            = resp_reg.value;
    assign m_resp_last             = resp_reg.last;

`ifndef ASSERT_OFF
    // no input transfer while a burst is running
    a_no_accept_in_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> !s_ready)
        else $error("input accepted during read burst");

    // burst bookkeeping is idle outside a burst
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (rd_left_reg == '0 && !pend_reg))
        else $error("read burst state left over in idle");

    // store read and write never meet in one cycle
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> !wr_en)
        else $error("store read and write in the same cycle");

    // the last burst value returns the core to idle with a marked result
    a_burst_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && pend_last_reg) |=> (state_reg == ST_IDLE && m_valid_reg && resp_reg.last))
        else $error("burst did not end on its last value");
`endif

endmodule

// ===== dv/tb.sv =====
// self-checking testbench for the burst register file access core
module tb
    import brfa_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         NREG             = NUM_REGISTERS_DEF;
    localparam int         HDR_LEN          = HEADER_LENGTH_DEF;
    // index outside the register list, the core should ignore it
    localparam logic [7:0] CFG_UNUSED_INDEX = 8'd200;
    // quiet cycles before a code change, covers transfers still in flight
    localparam int         SETTLE_CYCLES    = 8;
    // cycles without any transfer before the run is declared hung
    localparam int         WATCHDOG_LIMIT   = 1000;
    localparam int         RANDOM_ITEMS     = 290;
    localparam int         PHASE_ITEMS      = 75;
    localparam int         CODE_FRAMES      = 4;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // frame item channel
    logic       s_valid          = 1'b0;
    logic       s_ready;
    logic [7:0] s_frame_command  = 8'd0;
    logic [7:0] s_start_address  = 8'd0;
    logic [7:0] s_register_count = 8'd0;
    logic [7:0] s_payload_byte   = 8'd0;
    logic       s_payload_last   = 1'b0;

    // response channel
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_resp_command;
    logic [7:0] m_resp_length;
    logic [7:0] m_resp_address_or_error;
    logic [7:0] m_resp_count;
    logic [7:0] m_resp_value;
    logic       m_resp_last;

    // code register write channel
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [7:0]             cfg_data  = 8'd0;

    // mirror of the core: register contents, write position and command codes
    logic [7:0] reg_image [NREG];
    logic [5:0] wr_pos  = 6'd0;
    logic [7:0] wr_code = WRITE_CODE_RST;
    logic [7:0] rd_code = READ_CODE_RST;

    // codes the stimulus side builds frames with, kept apart from the mirror
    logic [7:0] stim_wr_code = WRITE_CODE_RST;
    logic [7:0] stim_rd_code = READ_CODE_RST;

    // responses predicted but not yet seen, oldest first
    resp_t due_responses [$];

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int burst_left     = 0;
    int ready_hold     = 0;

    burst_register_file_access_core #(
        .NUM_REGISTERS (NREG),
        .HEADER_LENGTH (HDR_LEN)
    ) DUT (
        .aclk                    (aclk),
        .aresetn                 (aresetn),
        .s_valid                 (s_valid),
        .s_ready                 (s_ready),
        .s_frame_command         (s_frame_command),
        .s_start_address         (s_start_address),
        .s_register_count        (s_register_count),
        .s_payload_byte          (s_payload_byte),
        .s_payload_last          (s_payload_last),
        .m_valid                 (m_valid),
        .m_ready                 (m_ready),
        .m_resp_command          (m_resp_command),
        .m_resp_length           (m_resp_length),
        .m_resp_address_or_error (m_resp_address_or_error),
        .m_resp_count            (m_resp_count),
        .m_resp_value            (m_resp_value),
        .m_resp_last             (m_resp_last),
        .cfg_valid               (cfg_valid),
        .cfg_ready               (cfg_ready),
        .cfg_index               (cfg_index),
        .cfg_data                (cfg_data)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        for (int i = 0; i < NREG; i++) reg_image[i] = 8'd0;
    end

    // receiver: ready runs of random length, short stalls, now and then a long clean stretch
    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (m_ready) begin
            m_ready    <= 1'b0;
            ready_hold <= $urandom_range(0, 7);
        end else begin
            m_ready    <= 1'b1;
            ready_hold <= ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(0, 15);
        end
    end

    function automatic void push_resp(logic [7:0] cmd, logic [7:0] len, logic [7:0] addr,
                                      logic [7:0] cnt, logic [7:0] val, logic last);
        resp_t r;
        r.command          = cmd;
        r.length           = len;
        r.address_or_error = addr;
        r.count            = cnt;
        r.value            = val;
        r.last             = last;
        due_responses.push_back(r);
    endfunction

    // advance the mirror by one accepted frame item and queue what it must answer
    function automatic void apply_frame_item(logic [7:0] cmd, logic [7:0] addr,
                                             logic [7:0] cnt, logic [7:0] pay, logic last);
        int         a;
        int         c;
        bit         hdr_ok;
        logic [7:0] err;
        a      = addr;
        c      = cnt;
        hdr_ok = 1'b1;
        err    = ERR_BAD_COUNT;
        // a bad address wins over a bad count
        if (a >= NREG) begin
            hdr_ok = 1'b0;
            err    = ERR_BAD_ADDRESS;
        end else if (c == 0 || a + c - 1 >= NREG) begin
            hdr_ok = 1'b0;
        end
        // equal codes: the write decode comes first
        if (cmd == wr_code) begin
            // bytes past the count are dropped, position keeps counting up to saturation
            if (hdr_ok && int'(wr_pos) < c) reg_image[a + int'(wr_pos)] = pay;
            if (hdr_ok && wr_pos != OFFSET_MAX) wr_pos = wr_pos + 6'd1;
            if (last) begin
                if (hdr_ok) push_resp(cmd, 8'(HDR_LEN), addr, cnt, 8'd0, 1'b1);
                else        push_resp(ERROR_COMMAND, ERROR_LENGTH, err, 8'd0, 8'd0, 1'b1);
            end
        end else if (cmd == rd_code) begin
            // a read answers at once, last mark or not
            if (hdr_ok) begin
                for (int i = 0; i < c; i++)
                    push_resp(cmd, 8'(HDR_LEN + c), addr, cnt, reg_image[a + i], i == c - 1);
            end else begin
                push_resp(ERROR_COMMAND, ERROR_LENGTH, err, 8'd0, 8'd0, 1'b1);
            end
            wr_pos = 6'd0;
        end else if (last) begin
            push_resp(ERROR_COMMAND, ERROR_LENGTH, ERR_BAD_COMMAND, 8'd0, 8'd0, 1'b1);
        end
        if (last) wr_pos = 6'd0;
    endfunction

    function automatic void compare_field(string fname, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, fname, want, got);
        end
    endfunction

    // one process sees every transfer: response check, mirror update, code writes, watchdog count
    always @(posedge aclk) begin : bus_monitor
        resp_t want;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            // responses first: an item taken at this edge cannot answer at this edge
            if (m_valid && m_ready) begin
                if (due_responses.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: response mismatch, expected none actual command %0d",
                             $time, m_resp_command);
                end else begin
                    want = due_responses.pop_front();
                    compare_field("command", want.command, m_resp_command);
                    compare_field("length", want.length, m_resp_length);
                    compare_field("address_or_error", want.address_or_error,
                                  m_resp_address_or_error);
                    compare_field("count", want.count, m_resp_count);
                    compare_field("value", want.value, m_resp_value);
                    compare_field("last", {7'd0, want.last}, {7'd0, m_resp_last});
                end
            end
            if (s_valid && s_ready)
                apply_frame_item(s_frame_command, s_start_address, s_register_count,
                                 s_payload_byte, s_payload_last);
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_WRITE_CODE)     wr_code = cfg_data;
                else if (cfg_index == CFG_READ_CODE) rd_code = cfg_data;
            end
        end
    end

    // hang detection
    initial begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("burst_register_file_access_core verification failed");
        $finish;
    end

    // one frame item; the sender runs in bursts with random gaps between them
    task automatic send_item(input logic [7:0] cmd, input logic [7:0] addr,
                             input logic [7:0] cnt, input logic [7:0] pay, input logic last);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        s_valid          <= 1'b1;
        s_frame_command  <= cmd;
        s_start_address  <= addr;
        s_register_count <= cnt;
        s_payload_byte   <= pay;
        s_payload_last   <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // nbytes items under one header, last mark on the final one
    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] addr,
                              input logic [7:0] cnt, input int nbytes);
        for (int i = 0; i < nbytes; i++)
            send_item(cmd, addr, cnt, 8'($urandom), i == nbytes - 1);
    endtask

    // stop sending, let every predicted response come out, then give the core time to settle
    task automatic drain_and_settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (due_responses.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // valid is left high so back to back writes need no lowering in between
    task automatic cfg_write(input logic [7:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic program_codes(input logic [7:0] wcode, input logic [7:0] rcode);
        cfg_write(CFG_WRITE_CODE, wcode);
        cfg_write(CFG_READ_CODE, rcode);
        cfg_valid    <= 1'b0;
        stim_wr_code  = wcode;
        stim_rd_code  = rcode;
    endtask

    // one random frame, mostly well formed; counted reports the items sent
    task automatic random_frame(output int counted);
        int         sel;
        int         vaddr;
        int         vcnt;
        int         nb;
        logic [7:0] cmd;
        sel     = $urandom_range(0, 99);
        vaddr   = $urandom_range(0, NREG - 1);
        vcnt    = $urandom_range(1, NREG - vaddr);
        counted = 0;
        if (sel < 40) begin
            send_frame(stim_wr_code, 8'(vaddr), 8'(vcnt), vcnt);
            counted = vcnt;
        end else if (sel < 46) begin
            // short write, last mark at or before the count
            nb = $urandom_range(1, vcnt);
            send_frame(stim_wr_code, 8'(vaddr), 8'(vcnt), nb);
            counted = nb;
        end else if (sel < 50) begin
            // extra bytes past the count
            nb = vcnt + $urandom_range(1, 4);
            send_frame(stim_wr_code, 8'(vaddr), 8'(vcnt), nb);
            counted = nb;
        end else if (sel < 52) begin
            // long enough for the write position to saturate
            nb = $urandom_range(64, 70);
            send_frame(stim_wr_code, 8'(vaddr), 8'(vcnt), nb);
            counted = nb;
        end else if (sel < 75) begin
            send_item(stim_rd_code, 8'(vaddr), 8'(vcnt), 8'($urandom), 1'($urandom));
            counted = 1;
        end else if (sel < 88) begin
            // full range header, mostly bad address or bad count
            cmd = $urandom_range(0, 1) ? stim_wr_code : stim_rd_code;
            nb  = (cmd == stim_wr_code) ? $urandom_range(1, 3) : 1;
            send_frame(cmd, 8'($urandom), 8'($urandom), nb);
            counted = nb;
        end else if (sel < 94) begin
            cmd = 8'($urandom);
            while (cmd == stim_wr_code || cmd == stim_rd_code) cmd = 8'($urandom);
            nb = $urandom_range(1, 3);
            send_frame(cmd, 8'($urandom), 8'($urandom), nb);
            counted = nb;
        end else begin
            // noise: any command, any header, any mark
            send_item(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
            counted = 1;
        end
    endtask

    task automatic exercise_codes(input int frames);
        int n;
        repeat (frames) random_frame(n);
    endtask

    // store must read all zero after reset
    task automatic test_reset_contents();
        send_item(stim_rd_code, 8'd0, 8'(NREG), 8'h00, 1'b0);
        send_item(stim_rd_code, 8'(NREG - 1), 8'd1, 8'hFF, 1'b1);
    endtask

    // single writes at both ends, full bursts, short and over-long frames, read inside a write
    task automatic test_burst_edges();
        send_item(stim_wr_code, 8'd0, 8'd1, 8'hFF, 1'b1);
        send_item(stim_wr_code, 8'(NREG - 1), 8'd1, 8'hA5, 1'b1);
        send_item(stim_wr_code, 8'd4, 8'd3, 8'h55, 1'b0);
        send_item(stim_wr_code, 8'd4, 8'd3, 8'hAA, 1'b0);
        send_item(stim_wr_code, 8'd4, 8'd3, 8'h00, 1'b1);
        send_item(stim_wr_code, 8'd10, 8'd4, 8'h3C, 1'b0);
        send_item(stim_wr_code, 8'd10, 8'd4, 8'hC3, 1'b1);
        send_item(stim_wr_code, 8'd20, 8'd2, 8'h11, 1'b0);
        send_item(stim_wr_code, 8'd20, 8'd2, 8'h22, 1'b0);
        send_item(stim_wr_code, 8'd20, 8'd2, 8'h33, 1'b0);
        send_item(stim_wr_code, 8'd20, 8'd2, 8'h44, 1'b1);
        // the read restarts the write position, so the next byte lands at the start address
        send_item(stim_wr_code, 8'd8, 8'd3, 8'h77, 1'b0);
        send_item(stim_rd_code, 8'd8, 8'd3, 8'h00, 1'b0);
        send_item(stim_wr_code, 8'd8, 8'd3, 8'h88, 1'b1);
        send_item(stim_rd_code, 8'd0, 8'(NREG), 8'hFF, 1'b1);
    endtask

    // bad address, bad count, both at once, unknown command with and without last mark
    task automatic test_header_errors();
        send_item(stim_wr_code, 8'hFF, 8'd1, 8'h5A, 1'b1);
        send_item(stim_rd_code, 8'(NREG), 8'd1, 8'h00, 1'b1);
        send_item(stim_rd_code, 8'd40, 8'd0, 8'h00, 1'b1);
        send_item(stim_rd_code, 8'd0, 8'd0, 8'h00, 1'b1);
        send_item(stim_rd_code, 8'd0, 8'hFF, 8'h00, 1'b0);
        send_item(stim_wr_code, 8'(NREG - 1), 8'd2, 8'hEE, 1'b0);
        send_item(stim_wr_code, 8'(NREG - 1), 8'd2, 8'hEE, 1'b1);
        send_item(8'h00, 8'd0, 8'd1, 8'h12, 1'b0);
        send_item(8'h00, 8'd0, 8'd1, 8'h34, 1'b1);
    endtask

    // code extremes, equal codes, a write to an unused index, then back to reset codes
    task automatic test_code_settings();
        drain_and_settle();
        program_codes(8'h00, 8'hFF);
        exercise_codes(CODE_FRAMES);
        drain_and_settle();
        program_codes(8'hFF, 8'h00);
        exercise_codes(CODE_FRAMES);
        drain_and_settle();
        program_codes(8'h5A, 8'h5A);
        exercise_codes(CODE_FRAMES);
        drain_and_settle();
        cfg_write(CFG_UNUSED_INDEX, 8'($urandom));
        cfg_valid <= 1'b0;
        exercise_codes(CODE_FRAMES);
        drain_and_settle();
        program_codes(WRITE_CODE_RST, READ_CODE_RST);
        exercise_codes(CODE_FRAMES);
    endtask

    // phases of random frames, each under its own pair of codes
    task automatic test_random_traffic();
        int         total;
        int         phase;
        int         n;
        logic [7:0] wcode;
        logic [7:0] rcode;
        total = 0;
        while (total < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0:       begin wcode = WRITE_CODE_RST; rcode = READ_CODE_RST; end
                1:       begin wcode = 8'h00;          rcode = 8'hFF;         end
                2:       begin wcode = 8'hFF;          rcode = 8'h00;         end
                3:       begin wcode = 8'($urandom);   rcode = wcode;         end
                default: begin wcode = 8'($urandom);   rcode = 8'($urandom);  end
            endcase
            drain_and_settle();
            program_codes(wcode, rcode);
            phase = 0;
            while (phase < PHASE_ITEMS) begin
                random_frame(n);
                phase += n;
            end
            total += phase;
        end
    endtask

    initial begin : test_sequence
        // synchronous reset held low at the start, then released
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_contents();
        test_burst_edges();
        test_header_errors();
        test_code_settings();
        test_random_traffic();
        drain_and_settle();
        if (mismatch_count == 0 && due_responses.size() == 0) begin
            $display("burst_register_file_access_core verification clean");
        end else begin
            $display("burst_register_file_access_core verification failed");
        end
        $finish;
    end

endmodule
